[rtl/sae_pkg.sv]
// Shared types and constants for the sorted array engine.
package sae_pkg;

   // Fixed field widths of the request and response channels.
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int POS_W     = 6;
   localparam int CNT_OUT_W = 7;

   // Command codes carried by a request.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SORT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TOP2   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

   // What the datapath does with each word that a scan reads back.
   localparam logic [1:0] MODE_SORT = 2'd0;
   localparam logic [1:0] MODE_INS  = 2'd1;
   localparam logic [1:0] MODE_TOP1 = 2'd2;
   localparam logic [1:0] MODE_TOP2 = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;        // latch the request payload
      logic       decode;        // clear per-request flags and results
      logic       cnt_clear;     // empty the store
      logic       cnt_inc;       // count one more element
      logic       append_wr;     // write the request value at the count
      logic       err_set;       // flag a refused append or insert
      logic       scan_start;    // restart the sequential scan at index zero
      logic       scan_load_end; // take the last scan index from the count
      logic       scan_run;      // issue reads and process returned words
      logic [1:0] mode;          // per-word operation of the scan
      logic       wb_sort;       // write the carried word at the end of a pass
      logic       wb_ins;        // write the carried word at the count
      logic       str_start;     // restart the stream index
      logic       str_read;      // read the element at the stream index
      logic       str_next;      // advance the stream index
      logic       rsp_single;    // load the single response
      logic       rsp_stream;    // load one streamed element
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;     // command of the request in progress
      logic             full;
      logic             empty;
      logic             lt2;     // fewer than two elements
      logic             scan_last;
      logic             sort_stop;
      logic             str_last;
      logic             slot_free;
   } ctl_status_type;

endpackage

[rtl/sae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/sae_ctrl.sv]
// Controller state machine that sequences every command of the engine.
module sae_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output sae_pkg::ctl_cmd_type    cmd,
   input  sae_pkg::ctl_status_type st
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SINGLE  = 4'd2;
   localparam logic [3:0] S_SORT    = 4'd3;
   localparam logic [3:0] S_SORT_WB = 4'd4;
   localparam logic [3:0] S_INS     = 4'd5;
   localparam logic [3:0] S_INS_WB  = 4'd6;
   localparam logic [3:0] S_TOP1    = 4'd7;
   localparam logic [3:0] S_TOP2    = 4'd8;
   localparam logic [3:0] S_STR_RD  = 4'd9;
   localparam logic [3:0] S_STR_OUT = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // A request is taken only between commands.
   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mode = sae_pkg::MODE_SORT;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_SINGLE;
            unique case (st.cmd)
               sae_pkg::CMD_CLEAR: begin
                  cmd.cnt_clear = 1'b1;
               end
               sae_pkg::CMD_APPEND: begin
                  if (st.full) begin
                     cmd.err_set = 1'b1;
                  end else begin
                     cmd.append_wr = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                  end
               end
               sae_pkg::CMD_SORT: begin
                  if (st.lt2) begin
                     if (!st.empty) begin
                        cmd.str_start = 1'b1;
                        state_in      = S_STR_RD;
                     end
                  end else begin
                     cmd.scan_start    = 1'b1;
                     cmd.scan_load_end = 1'b1;
                     state_in          = S_SORT;
                  end
               end
               sae_pkg::CMD_INSERT: begin
                  if (st.full) begin
                     cmd.err_set = 1'b1;
                  end else if (st.empty) begin
                     state_in = S_INS_WB;
                  end else begin
                     cmd.scan_start    = 1'b1;
                     cmd.scan_load_end = 1'b1;
                     state_in          = S_INS;
                  end
               end
               sae_pkg::CMD_TOP2: begin
                  if (!st.empty) begin
                     cmd.scan_start    = 1'b1;
                     cmd.scan_load_end = 1'b1;
                     state_in          = S_TOP1;
                  end
               end
               sae_pkg::CMD_READ: begin
                  if (!st.empty) begin
                     cmd.str_start = 1'b1;
                     state_in      = S_STR_RD;
                  end
               end
               default: begin
                  state_in = S_SINGLE;
               end
            endcase
         end
         S_SINGLE: begin
            if (st.slot_free) begin
               cmd.rsp_single = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SORT: begin
            cmd.scan_run = 1'b1;
            cmd.mode     = sae_pkg::MODE_SORT;
            if (st.scan_last) begin
               state_in = S_SORT_WB;
            end
         end
         S_SORT_WB: begin
            cmd.wb_sort = 1'b1;
            if (st.sort_stop) begin
               cmd.str_start = 1'b1;
               state_in      = S_STR_RD;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SORT;
            end
         end
         S_INS: begin
            cmd.scan_run = 1'b1;
            cmd.mode     = sae_pkg::MODE_INS;
            if (st.scan_last) begin
               state_in = S_INS_WB;
            end
         end
         S_INS_WB: begin
            cmd.wb_ins    = 1'b1;
            cmd.str_start = 1'b1;
            state_in      = S_STR_RD;
         end
         S_TOP1: begin
            cmd.scan_run = 1'b1;
            cmd.mode     = sae_pkg::MODE_TOP1;
            if (st.scan_last) begin
               cmd.scan_start    = 1'b1;
               cmd.scan_load_end = 1'b1;
               state_in          = S_TOP2;
            end
         end
         S_TOP2: begin
            cmd.scan_run = 1'b1;
            cmd.mode     = sae_pkg::MODE_TOP2;
            if (st.scan_last) begin
               state_in = S_SINGLE;
            end
         end
         S_STR_RD: begin
            cmd.str_read = 1'b1;
            state_in     = S_STR_OUT;
         end
         S_STR_OUT: begin
            if (st.slot_free) begin
               cmd.rsp_stream = 1'b1;
               if (st.str_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.str_next = 1'b1;
                  state_in     = S_STR_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/sae_datapath.sv]
// Datapath: element store, count, scan pipeline, compare logic and response register.
module sae_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [sae_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [sae_pkg::DATA_W-1:0]    req_value,
   input  sae_pkg::ctl_cmd_type                 cmd,
   output sae_pkg::ctl_status_type              st,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sae_pkg::DATA_W-1:0]    rsp_element,
   output logic [sae_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_element_valid,
   output logic signed [sae_pkg::DATA_W-1:0]    rsp_second_value,
   output logic [sae_pkg::POS_W-1:0]            rsp_second_position,
   output logic                                 rsp_second_valid,
   output logic [sae_pkg::CNT_OUT_W-1:0]        rsp_count,
   output logic                                 rsp_full_error,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DW    = sae_pkg::DATA_W;
   localparam int PW    = sae_pkg::POS_W;
   localparam int CW    = sae_pkg::CNT_OUT_W;

   // Control registers.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             issuing_ff, issuing_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic             found_ff, found_in;
   logic             f1_ff, f1_in;
   logic             f2_ff, f2_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload and index registers.
   logic [sae_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic signed [DW-1:0]      value_ff, value_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]          pipe_idx_ff, pipe_idx_in;
   logic [IDX_W-1:0]          scan_end_ff, scan_end_in;
   logic signed [DW-1:0]      carried_ff, carried_in;
   logic signed [DW-1:0]      m1_ff, m1_in;
   logic signed [DW-1:0]      m2_ff, m2_in;
   logic [IDX_W-1:0]          p1_ff, p1_in;
   logic [IDX_W-1:0]          p2_ff, p2_in;

   // Response register.
   logic signed [DW-1:0] rsp_element_ff, rsp_element_in;
   logic [PW-1:0]        rsp_position_ff, rsp_position_in;
   logic                 rsp_element_valid_ff, rsp_element_valid_in;
   logic signed [DW-1:0] rsp_second_value_ff, rsp_second_value_in;
   logic [PW-1:0]        rsp_second_position_ff, rsp_second_position_in;
   logic                 rsp_second_valid_ff, rsp_second_valid_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;
   logic                 rsp_full_error_ff, rsp_full_error_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Store ports.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DW-1:0]        wr_data;
   logic                 rd_en;
   logic [DW-1:0]        rd_raw;
   logic signed [DW-1:0] rd_data;

   // Positions and count widened, then cut to the response field widths.
   logic [PW+IDX_W-1:0] str_pos_w, p1_pos_w, p2_pos_w;
   logic [CW+CNT_W-1:0] count_w;
   logic                str_last;

   sae_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_raw)
   );

   assign rd_data   = rd_raw;
   assign str_pos_w = {{PW{1'b0}}, rd_idx_ff};
   assign p1_pos_w  = {{PW{1'b0}}, p1_ff};
   assign p2_pos_w  = {{PW{1'b0}}, p2_ff};
   assign count_w   = {{CW{1'b0}}, count_ff};
   assign str_last  = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   // Status toward the controller.
   always_comb begin
      st.cmd       = cmd_ff;
      st.full      = (count_ff == CNT_W'(DEPTH));
      st.empty     = (count_ff == '0);
      st.lt2       = (count_ff < CNT_W'(2));
      st.scan_last = pipe_vld_ff && (pipe_idx_ff == scan_end_ff);
      st.sort_stop = (scan_end_ff == IDX_W'(1));
      st.str_last  = str_last;
      st.slot_free = !rsp_valid_ff || rsp_ready;
   end

   // Next values of all datapath registers and the store ports.
   always_comb begin
      count_in     = count_ff;
      issuing_in   = issuing_ff;
      pipe_vld_in  = 1'b0;
      found_in     = found_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      err_in       = err_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      rd_idx_in    = rd_idx_ff;
      pipe_idx_in  = pipe_idx_ff;
      scan_end_in  = scan_end_ff;
      carried_in   = carried_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = value_ff;
      rd_en        = 1'b0;

      // Take a new request.
      if (cmd.accept) begin
         cmd_in   = req_cmd;
         value_in = req_value;
      end

      // Start of a command: both top searches begin from minus one.
      if (cmd.decode) begin
         found_in   = 1'b0;
         f1_in      = 1'b0;
         f2_in      = 1'b0;
         err_in     = 1'b0;
         m1_in      = -DW'(1);
         m2_in      = -DW'(1);
         p1_in      = '0;
         p2_in      = '0;
         carried_in = value_ff;
      end

      // Count updates and appending.
      if (cmd.cnt_clear) begin
         count_in = '0;
      end
      if (cmd.err_set) begin
         err_in = 1'b1;
      end
      if (cmd.append_wr) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = value_ff;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end

      // Scan: one read issued per cycle, the word returned by the previous read processed.
      if (cmd.scan_run) begin
         if (issuing_ff) begin
            rd_en       = 1'b1;
            pipe_vld_in = 1'b1;
            pipe_idx_in = rd_idx_ff;
            if (rd_idx_ff == scan_end_ff) begin
               issuing_in = 1'b0;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         if (pipe_vld_ff) begin
            unique case (cmd.mode)
               sae_pkg::MODE_SORT: begin
                  // Carry the larger word up; equal words keep their order.
                  if (pipe_idx_ff == '0) begin
                     carried_in = rd_data;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = pipe_idx_ff - IDX_W'(1);
                     if (carried_ff > rd_data) begin
                        wr_data = rd_data;
                     end else begin
                        wr_data    = carried_ff;
                        carried_in = rd_data;
                     end
                  end
               end
               sae_pkg::MODE_INS: begin
                  // From the first larger word on, every word moves up one.
                  if (found_ff || (rd_data > value_ff)) begin
                     wr_en      = 1'b1;
                     wr_addr    = pipe_idx_ff;
                     wr_data    = carried_ff;
                     carried_in = rd_data;
                     found_in   = 1'b1;
                  end
               end
               sae_pkg::MODE_TOP1: begin
                  if (rd_data > m1_ff) begin
                     m1_in = rd_data;
                     p1_in = pipe_idx_ff;
                     f1_in = 1'b1;
                  end
               end
               sae_pkg::MODE_TOP2: begin
                  if ((rd_data > m2_ff) && (rd_data < m1_ff)) begin
                     m2_in = rd_data;
                     p2_in = pipe_idx_ff;
                     f2_in = 1'b1;
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
      end

      // A scan restart wins over the read index, issue and pipeline valid updates of the same cycle.
      if (cmd.scan_start) begin
         rd_idx_in   = '0;
         issuing_in  = 1'b1;
         pipe_vld_in = 1'b0;
         if (cmd.scan_load_end) begin
            scan_end_in = IDX_W'(count_ff - CNT_W'(1));
         end
      end

      // Closing writes of a sort pass and of an insert.
      if (cmd.wb_sort) begin
         wr_en       = 1'b1;
         wr_addr     = scan_end_ff;
         wr_data     = carried_ff;
         scan_end_in = scan_end_ff - IDX_W'(1);
      end
      if (cmd.wb_ins) begin
         wr_en    = 1'b1;
         wr_addr  = count_ff[IDX_W-1:0];
         wr_data  = carried_ff;
         count_in = count_ff + CNT_W'(1);
      end

      // Stream index.
      if (cmd.str_start) begin
         rd_idx_in = '0;
      end
      if (cmd.str_read) begin
         rd_en = 1'b1;
      end
      if (cmd.str_next) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   // Response register loading.
   always_comb begin
      rsp_valid_in           = rsp_valid_ff && !rsp_ready;
      rsp_element_in         = rsp_element_ff;
      rsp_position_in        = rsp_position_ff;
      rsp_element_valid_in   = rsp_element_valid_ff;
      rsp_second_value_in    = rsp_second_value_ff;
      rsp_second_position_in = rsp_second_position_ff;
      rsp_second_valid_in    = rsp_second_valid_ff;
      rsp_count_in           = rsp_count_ff;
      rsp_full_error_in      = rsp_full_error_ff;
      rsp_last_in            = rsp_last_ff;
      if (cmd.rsp_single) begin
         rsp_valid_in           = 1'b1;
         rsp_element_in         = f1_ff ? m1_ff : '0;
         rsp_position_in        = f1_ff ? p1_pos_w[PW-1:0] : '0;
         rsp_element_valid_in   = f1_ff;
         rsp_second_value_in    = f2_ff ? m2_ff : '0;
         rsp_second_position_in = f2_ff ? p2_pos_w[PW-1:0] : '0;
         rsp_second_valid_in    = f2_ff;
         rsp_count_in           = count_w[CW-1:0];
         rsp_full_error_in      = err_ff;
         rsp_last_in            = 1'b1;
      end else if (cmd.rsp_stream) begin
         rsp_valid_in           = 1'b1;
         rsp_element_in         = rd_data;
         rsp_position_in        = str_pos_w[PW-1:0];
         rsp_element_valid_in   = 1'b1;
         rsp_second_value_in    = '0;
         rsp_second_position_in = '0;
         rsp_second_valid_in    = 1'b0;
         rsp_count_in           = count_w[CW-1:0];
         rsp_full_error_in      = 1'b0;
         rsp_last_in            = str_last;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issuing_ff   <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         f1_ff        <= 1'b0;
         f2_ff        <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issuing_ff   <= issuing_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         f1_ff        <= f1_in;
         f2_ff        <= f2_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff                 <= cmd_in;
      value_ff               <= value_in;
      rd_idx_ff              <= rd_idx_in;
      pipe_idx_ff            <= pipe_idx_in;
      scan_end_ff            <= scan_end_in;
      carried_ff             <= carried_in;
      m1_ff                  <= m1_in;
      m2_ff                  <= m2_in;
      p1_ff                  <= p1_in;
      p2_ff                  <= p2_in;
      rsp_element_ff         <= rsp_element_in;
      rsp_position_ff        <= rsp_position_in;
      rsp_element_valid_ff   <= rsp_element_valid_in;
      rsp_second_value_ff    <= rsp_second_value_in;
      rsp_second_position_ff <= rsp_second_position_in;
      rsp_second_valid_ff    <= rsp_second_valid_in;
      rsp_count_ff           <= rsp_count_in;
      rsp_full_error_ff      <= rsp_full_error_in;
      rsp_last_ff            <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_element         = rsp_element_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_element_valid   = rsp_element_valid_ff;
   assign rsp_second_value    = rsp_second_value_ff;
   assign rsp_second_position = rsp_second_position_ff;
   assign rsp_second_valid    = rsp_second_valid_ff;
   assign rsp_count           = rsp_count_ff;
   assign rsp_full_error      = rsp_full_error_ff;
   assign rsp_last            = rsp_last_ff;

   // The element count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above store depth");

   // A word in the scan pipeline never lies past the last scan index.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> (pipe_idx_ff <= scan_end_ff))
      else $error("scan read past its end");

   // A response is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_single || cmd.rsp_stream) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // The closing write of an insert grows the store by one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_ins |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the store");

endmodule

[rtl/sorted_array_engine_unit.sv]
// Top level of the sorted array engine: controller plus datapath.
// Clear, append, refused writes, unused codes and sort, top two or read of an empty store
// load a single response. Read streams out the elements one by one. Top two on n>0
// elements makes two scans over the one read port. An insert streams after one scan of
// n>0 elements, or at once when empty; a sort of n>1 elements streams after n-1 passes.
// Reset sets count zero; requests are taken only while idle.
module sorted_array_engine_unit #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sae_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [sae_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sae_pkg::DATA_W-1:0]    rsp_element,
   output logic [sae_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_element_valid,
   output logic signed [sae_pkg::DATA_W-1:0]    rsp_second_value,
   output logic [sae_pkg::POS_W-1:0]            rsp_second_position,
   output logic                                 rsp_second_valid,
   output logic [sae_pkg::CNT_OUT_W-1:0]        rsp_count,
   output logic                                 rsp_full_error,
   output logic                                 rsp_last
);

   sae_pkg::ctl_cmd_type    ctl_cmd;
   sae_pkg::ctl_status_type ctl_status;

   // Command sequencing.
   sae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (ctl_cmd),
      .st        (ctl_status)
   );

   // Store, compare logic and response register.
   sae_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_value           (req_value),
      .cmd                 (ctl_cmd),
      .st                  (ctl_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_element         (rsp_element),
      .rsp_position        (rsp_position),
      .rsp_element_valid   (rsp_element_valid),
      .rsp_second_value    (rsp_second_value),
      .rsp_second_position (rsp_second_position),
      .rsp_second_valid    (rsp_second_valid),
      .rsp_count           (rsp_count),
      .rsp_full_error      (rsp_full_error),
      .rsp_last            (rsp_last)
   );

endmodule
